@@ rtl/sbsh_pkg.sv @@
// Shared types, constants and helper functions of the SHA-1 byte stream hasher.
package sbsh_pkg;

	localparam int WordW       = 32;
	localparam int BlockWords  = 16;
	localparam int DigestWords = 5;
	localparam int CountW      = 61;

	typedef logic [WordW-1:0] word_t;

	// Input item: one message byte or a finish request.
	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} msg_item_t;

	// Output item: one digest word.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	// Working variables of the compression rounds.
	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t e;
	} work_t;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [6:0] LastRound  = 7'd79;
	localparam logic [2:0] LastWord   = 3'd4;
	localparam logic [3:0] LenHiWord  = 4'd14;
	localparam logic [3:0] LenLoWord  = 4'd15;

	// Initial chaining value for digest word idx.
	function automatic word_t init_word(input logic [2:0] idx);
		word_t v;
		case (idx)
			3'd0:    v = 32'h67452301;
			3'd1:    v = 32'hefcdab89;
			3'd2:    v = 32'h98badcfe;
			3'd3:    v = 32'h10325476;
			default: v = 32'hc3d2e1f0;
		endcase
		return v;
	endfunction

	// Round constant for each group of twenty rounds.
	function automatic word_t round_k(input logic [1:0] phase);
		word_t v;
		case (phase)
			2'd0:    v = 32'h5A827999;
			2'd1:    v = 32'h6ED9EBA1;
			2'd2:    v = 32'h8F1BBCDC;
			default: v = 32'hCA62C1D6;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/sha1_byte_stream_hasher.sv @@
// SHA-1 hasher top level: byte packing, padding sequencer, round loop and digest output.
// Data bytes are taken while idle; the 64th byte of a block starts the round loop and the
// chaining update, all on the single shared round unit. A finish pads one final block, or
// pads a block and then one more when the length does not fit after the marker byte; the
// five digest words follow, each held until the consumer is ready.
// Reset (arst_n low, asynchronous) loads the initial chaining words, clears the byte
// count and leaves the block idle and ready; the block buffer itself is not cleared.
module sha1_byte_stream_hasher
	import sbsh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_item_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_item_t dig
);

	// Sequencer states. IDLE takes items; PAD shifts padding and length words into
	// the buffer; ROUND runs one compression round per cycle; ADD folds the
	// working variables into the chaining words; OUT hands out the digest.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_PAD   = 5'b00010,
		ST_ROUND = 5'b00100,
		ST_ADD   = 5'b01000,
		ST_OUT   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CountW-1:0] cnt_q;
	logic [23:0]       acc_q;
	word_t             sched_q [BlockWords];
	logic [3:0]        wcnt_q;
	logic [6:0]        rnd_q;
	work_t             work_q;
	word_t             h_q [DigestWords];
	logic              fin_q;
	logic              two_q;
	logic [2:0]        oidx_q;
	logic              dig_valid_q;
	dig_item_t         dig_q;

	logic       msg_fire;
	logic [5:0] pos;
	logic       push_en;
	word_t      push_word;
	word_t      pad_word;
	word_t      len_word;
	logic       out_load;
	work_t      work_next;
	word_t      sched_word;

	assign msg_ready = (state_q == ST_IDLE);
	assign msg_fire  = msg_valid && msg_ready;
	assign pos       = cnt_q[5:0];
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;
	assign out_load  = (state_q == ST_OUT) && (!dig_valid_q || dig_ready);

	// The buffer is a sixteen-word shift line: the newest word enters at the top,
	// so after sixteen pushes the oldest word of the block sits at the bottom.
	// The same line carries the message schedule during the rounds.
	sbsh_round u_round (
		.work       (work_q),
		.w0         (sched_q[0]),
		.w2         (sched_q[2]),
		.w8         (sched_q[8]),
		.w13        (sched_q[13]),
		.rnd        (rnd_q),
		.work_next  (work_next),
		.sched_word (sched_word)
	);

	// First padding word: the bytes already gathered, the marker byte, then zeros.
	always_comb begin
		case (pos[1:0])
			2'd0:    pad_word = {PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			default: pad_word = {acc_q, PAD_BYTE};
		endcase
	end

	// The bit length goes into the last two words of the final block, but only
	// once any extra block forced by a late marker byte has been compressed.
	always_comb begin
		if (!two_q && wcnt_q == LenHiWord) begin
			len_word = cnt_q[60:29];
		end else if (!two_q && wcnt_q == LenLoWord) begin
			len_word = {cnt_q[28:0], 3'b000};
		end else begin
			len_word = '0;
		end
	end

	always_comb begin
		push_en   = 1'b0;
		push_word = len_word;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_fire && msg.kind == KIND_FINISH) begin
					push_en   = 1'b1;
					push_word = pad_word;
				end else if (msg_fire && pos[1:0] == 2'd3) begin
					push_en   = 1'b1;
					push_word = {acc_q, msg.data_byte};
				end
			end
			ST_PAD: begin
				push_en = !(two_q && wcnt_q == 4'd0);
			end
			ST_ROUND, ST_ADD, ST_OUT: begin
				push_en = 1'b0;
			end
			default: begin
				push_en = 1'b0;
			end
		endcase
	end

	// Buffer, byte gatherer and working variables carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[BlockWords-1] <= sched_word;
			work_q <= work_next;
		end else if (push_en) begin
			for (int i = 0; i < BlockWords - 1; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[BlockWords-1] <= push_word;
		end
		if (msg_fire && msg.kind == KIND_DATA) begin
			acc_q <= {acc_q[15:0], msg.data_byte};
		end
		if ((state_q == ST_IDLE && msg_fire && msg.kind == KIND_DATA && pos == 6'd63) ||
			(state_q == ST_PAD && ((two_q && wcnt_q == 4'd0) ||
			(!two_q && wcnt_q == LenLoWord)))) begin
			work_q.a <= h_q[0];
			work_q.b <= h_q[1];
			work_q.c <= h_q[2];
			work_q.d <= h_q[3];
			work_q.e <= h_q[4];
		end
		if (out_load) begin
			dig_q.digest_word <= h_q[oidx_q];
			dig_q.word_index  <= oidx_q;
			dig_q.last_word   <= (oidx_q == LastWord);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			wcnt_q      <= '0;
			rnd_q       <= '0;
			fin_q       <= 1'b0;
			two_q       <= 1'b0;
			oidx_q      <= '0;
			dig_valid_q <= 1'b0;
			for (int i = 0; i < DigestWords; i++) begin
				h_q[i] <= init_word(3'(i));
			end
		end else begin
			if (push_en) begin
				wcnt_q <= wcnt_q + 4'd1;
			end
			if (out_load) begin
				dig_valid_q <= 1'b1;
			end else if (dig_ready) begin
				dig_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_fire && msg.kind == KIND_FINISH) begin
						fin_q   <= 1'b1;
						two_q   <= (pos[5:3] == 3'b111);
						state_q <= ST_PAD;
					end else if (msg_fire) begin
						cnt_q <= cnt_q + CountW'(1);
						if (pos == 6'd63) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_PAD: begin
					if ((two_q && wcnt_q == 4'd0) || (!two_q && wcnt_q == LenLoWord)) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == LastRound) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0] <= h_q[0] + work_q.a;
					h_q[1] <= h_q[1] + work_q.b;
					h_q[2] <= h_q[2] + work_q.c;
					h_q[3] <= h_q[3] + work_q.d;
					h_q[4] <= h_q[4] + work_q.e;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (two_q) begin
						// The marker left no room for the length; the length needs one more block.
						two_q   <= 1'b0;
						state_q <= ST_PAD;
					end else begin
						oidx_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == LastWord) begin
							// Digest handed out: start a fresh message.
							cnt_q   <= '0;
							fin_q   <= 1'b0;
							state_q <= ST_IDLE;
							for (int i = 0; i < DigestWords; i++) begin
								h_q[i] <= init_word(3'(i));
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The last flag marks exactly the fifth digest word.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig.last_word == (dig.word_index == LastWord)))
		else $error("last_word does not match word_index");

	// The 64th data byte of a block starts the compression at once.
	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_fire && msg.kind == KIND_DATA && pos == 6'd63) |=> (state_q == ST_ROUND))
		else $error("full block did not start compression");

	// Eighty rounds, then the chaining update.
	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == LastRound) |=> (state_q == ST_ADD))
		else $error("round loop did not end after the last round");

endmodule

@@ rtl/sbsh_round.sv @@
// One SHA-1 round: message schedule word, round function and working-variable update.
module sbsh_round
	import sbsh_pkg::*;
(
	input  work_t      work,
	input  word_t      w0,
	input  word_t      w2,
	input  word_t      w8,
	input  word_t      w13,
	input  logic [6:0] rnd,
	output work_t      work_next,
	output word_t      sched_word
);

	logic [1:0] phase;
	word_t      mix;
	word_t      f;
	word_t      tmp;

	always_comb begin
		if (rnd < 7'd20) begin
			phase = 2'd0;
		end else if (rnd < 7'd40) begin
			phase = 2'd1;
		end else if (rnd < 7'd60) begin
			phase = 2'd2;
		end else begin
			phase = 2'd3;
		end
	end

	// The first sixteen rounds use the block words as they were loaded.
	assign mix        = w13 ^ w8 ^ w2 ^ w0;
	assign sched_word = (rnd < 7'd16) ? w0 : {mix[30:0], mix[31]};

	always_comb begin
		case (phase)
			2'd0:    f = work.d ^ (work.b & (work.c ^ work.d));
			2'd2:    f = (work.b & work.c) | (work.d & (work.b | work.c));
			default: f = work.b ^ work.c ^ work.d;
		endcase
	end

	assign tmp = {work.a[26:0], work.a[31:27]} + f + work.e + round_k(phase) + sched_word;

	assign work_next.a = tmp;
	assign work_next.b = work.a;
	assign work_next.c = {work.b[1:0], work.b[31:2]};
	assign work_next.d = work.c;
	assign work_next.e = work.d;

endmodule
